// ----- rtl/psrt_pkg.sv -----
// ----------------------------------------------------------------------------
// psrt_pkg
// Shared types, widths and constants of the point scale/rotate/translate block.
// ----------------------------------------------------------------------------
package psrt_pkg;

  // Field and register widths
  localparam int COORD_WIDTH   = 16;
  localparam int ANGLE_WIDTH   = 13;
  localparam int CFG_WIDTH     = COORD_WIDTH;
  localparam int CFG_IDX_WIDTH = 3;

  // Rotation chain
  localparam int DEF_ROTATION_STAGES = 16;
  localparam int ATAN_ENTRIES        = 24;
  localparam int VEC_WIDTH           = 32;
  localparam int PHASE_WIDTH         = 32;
  localparam logic signed [VEC_WIDTH-1:0]   CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [PHASE_WIDTH-1:0] QUARTER_TURN = 32'sd1073741824;

  // Angle to binary phase: phase = ang * PHASE_STEP + (2 * ang + 22) / 45
  localparam logic [ANGLE_WIDTH-1:0] FULL_TURN = 13'd5760;
  localparam int PHASE_STEP_WIDTH = 20;
  localparam logic [PHASE_STEP_WIDTH-1:0] PHASE_STEP = 20'd745654;
  localparam int ROUND_ARG_WIDTH = ANGLE_WIDTH + 1;
  localparam logic [ROUND_ARG_WIDTH-1:0] ROUND_BIAS = 14'd22;
  localparam int RECIP_WIDTH = 15;
  localparam logic [RECIP_WIDTH-1:0] RECIP_45 = 15'd23302;
  localparam int RECIP_SHIFT = 20;

  // Datapath widths after the rotation chain
  localparam int PROD_WIDTH    = 2 * COORD_WIDTH;
  localparam int SCALE_FRAC    = 8;
  localparam int SCALED_WIDTH  = PROD_WIDTH - SCALE_FRAC;
  localparam int TRIG_WIDTH    = 16;
  localparam int TRIG_FRAC     = 14;
  localparam int TRIG_DROP     = 16;
  localparam int MIX_WIDTH     = SCALED_WIDTH + TRIG_WIDTH;
  localparam int SUM_WIDTH     = MIX_WIDTH + 1;
  localparam int ROT_WIDTH     = SUM_WIDTH - TRIG_FRAC;
  localparam int TRANS_WIDTH   = ROT_WIDTH + 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_SCALE_X   = 3'd0,
    REG_SCALE_Y   = 3'd1,
    REG_ROT_ANGLE = 3'd2,
    REG_SHIFT_X   = 3'd3,
    REG_SHIFT_Y   = 3'd4
  } cfg_reg_e;

  // Input transaction
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
  } point_t;

  // Output transaction
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic                          clipped;
  } result_t;

  // Data handed from cell to cell: rotation vector, residual phase, scaled point
  typedef struct packed {
    logic signed [VEC_WIDTH-1:0]    x;
    logic signed [VEC_WIDTH-1:0]    y;
    logic signed [PHASE_WIDTH-1:0]  z;
    logic signed [SCALED_WIDTH-1:0] a;
    logic signed [SCALED_WIDTH-1:0] b;
  } rot_t;

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn
  function automatic logic signed [PHASE_WIDTH-1:0] atan_phase(input int unsigned idx);
    logic signed [PHASE_WIDTH-1:0] val;
    unique case (idx)
      0:       val = 32'sh20000000;
      1:       val = 32'sh12E4051E;
      2:       val = 32'sh09FB385B;
      3:       val = 32'sh051111D4;
      4:       val = 32'sh028B0D43;
      5:       val = 32'sh0145D7E1;
      6:       val = 32'sh00A2F61E;
      7:       val = 32'sh00517C55;
      8:       val = 32'sh0028BE53;
      9:       val = 32'sh00145F2F;
      10:      val = 32'sh000A2F98;
      11:      val = 32'sh000517CC;
      12:      val = 32'sh00028BE6;
      13:      val = 32'sh000145F3;
      14:      val = 32'sh0000A2F9;
      15:      val = 32'sh0000517C;
      16:      val = 32'sh000028BE;
      17:      val = 32'sh0000145F;
      18:      val = 32'sh00000A2F;
      19:      val = 32'sh00000517;
      20:      val = 32'sh0000028B;
      21:      val = 32'sh00000145;
      22:      val = 32'sh000000A2;
      23:      val = 32'sh00000051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/point_scale_rotate_translate.sv -----
// ----------------------------------------------------------------------------
// point_scale_rotate_translate
// Scales a 2D Q8.8 point per axis, rotates it about the origin and translates
// it, saturating to the coordinate range.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+----------------------------
//  cfg      | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//  in       | in        | in_valid_i, in_stall_o | in_data_i  (point_t)
//  out      | out       | out_valid_o, out_stall_i | out_data_o (result_t)
//
//  One transaction per cycle sustained while the output is not stalled; the
//  pipeline is the chain of rotation cells (one micro-rotation per cell) plus
//  two front stages and four back stages.
//  Every stage has its own valid bit, so bubbles are squeezed out while the
//  output is stalled and new transactions still enter.
//  Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module point_scale_rotate_translate
  import psrt_pkg::*;
#(
  parameter int ROTATION_STAGES = DEF_ROTATION_STAGES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]     cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  point_t                   in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output result_t                  out_data_o
);

  // Configuration registers
  logic signed [COORD_WIDTH-1:0] scale_x_q, scale_y_q, shift_x_q, shift_y_q;
  logic [ANGLE_WIDTH-1:0]        angle_q;

  // Take register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= COORD_WIDTH'(1 << SCALE_FRAC);
      scale_y_q <= COORD_WIDTH'(1 << SCALE_FRAC);
      angle_q   <= '0;
      shift_x_q <= '0;
      shift_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SCALE_X:   scale_x_q <= cfg_data_i[COORD_WIDTH-1:0];
        REG_SCALE_Y:   scale_y_q <= cfg_data_i[COORD_WIDTH-1:0];
        REG_ROT_ANGLE: angle_q   <= cfg_data_i[ANGLE_WIDTH-1:0];
        REG_SHIFT_X:   shift_x_q <= cfg_data_i[COORD_WIDTH-1:0];
        REG_SHIFT_Y:   shift_y_q <= cfg_data_i[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline links
  logic chain_valid [0:ROTATION_STAGES];
  logic chain_ready [0:ROTATION_STAGES];
  rot_t chain_data  [0:ROTATION_STAGES];
  logic in_ready;

  psrt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .angle_i     (angle_q),
    .scale_x_i   (scale_x_q),
    .scale_y_i   (scale_y_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data_i),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_data_o  (chain_data[0])
  );

  // Row of rotation cells
  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
    psrt_cell #(
      .STAGE(i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[i]),
      .in_ready_o  (chain_ready[i]),
      .in_data_i   (chain_data[i]),
      .out_valid_o (chain_valid[i+1]),
      .out_ready_i (chain_ready[i+1]),
      .out_data_o  (chain_data[i+1])
    );
  end

  psrt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_x_i   (shift_x_q),
    .shift_y_i   (shift_y_q),
    .in_valid_i  (chain_valid[ROTATION_STAGES]),
    .in_ready_o  (chain_ready[ROTATION_STAGES]),
    .in_data_i   (chain_data[ROTATION_STAGES]),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = !in_ready;

  // An empty output register frees the whole chain
  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("point_scale_rotate_translate: input stalled with empty output");

  // An input stall while the output is not stalled implies a pending output
  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && !out_stall_i) |-> out_valid_o)
    else $error("point_scale_rotate_translate: stall without pending output");

endmodule

// ----- rtl/psrt_front.sv -----
// ----------------------------------------------------------------------------
// psrt_front
// Two pipeline stages ahead of the rotation chain: angle to binary phase and
// per-axis scaling, then quarter-turn fold and Q8.8 rounding of the scaled point.
// ----------------------------------------------------------------------------
module psrt_front
  import psrt_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ANGLE_WIDTH-1:0]        angle_i,
  input  logic signed [COORD_WIDTH-1:0] scale_x_i,
  input  logic signed [COORD_WIDTH-1:0] scale_y_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  point_t                        in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rot_t                          out_data_o
);

  localparam int BASE_WIDTH  = ANGLE_WIDTH + PHASE_STEP_WIDTH;
  localparam int RPROD_WIDTH = ROUND_ARG_WIDTH + RECIP_WIDTH;
  localparam logic signed [PROD_WIDTH-1:0] HALF_LSB = PROD_WIDTH'(1 << (SCALE_FRAC - 1));

  // Stage 1 -----------------------------------------------------------------
  logic [ANGLE_WIDTH-1:0]      angle_red;
  logic [ROUND_ARG_WIDTH-1:0]  round_arg;
  logic [RPROD_WIDTH-1:0]      round_prod;
  logic [BASE_WIDTH-1:0]       phase_base;
  logic [BASE_WIDTH-1:0]       phase_sum;
  logic signed [PROD_WIDTH-1:0] prod_x, prod_y;

  logic                         s1_valid_q, s1_valid_d, s1_ready;
  logic [PHASE_WIDTH-1:0]       s1_phase_q;
  logic signed [PROD_WIDTH-1:0] s1_px_q, s1_py_q;

  // Reduce one full turn, then form the phase as a constant multiply plus rounding term
  assign angle_red  = (angle_i >= FULL_TURN) ? angle_i - FULL_TURN : angle_i;
  assign round_arg  = {angle_red, 1'b0} + ROUND_BIAS;
  assign round_prod = round_arg * RECIP_45;
  assign phase_base = angle_red * PHASE_STEP;
  assign phase_sum  = phase_base + BASE_WIDTH'(round_prod[RPROD_WIDTH-1:RECIP_SHIFT]);

  // Scale each axis
  assign prod_x = PROD_WIDTH'($signed(in_data_i.point_x) * scale_x_i);
  assign prod_y = PROD_WIDTH'($signed(in_data_i.point_y) * scale_y_i);

  // Stage 2 -----------------------------------------------------------------
  logic                          s2_valid_q, s2_valid_d, s2_ready;
  rot_t                          s2_data_q, s2_data_d;
  logic signed [PHASE_WIDTH-1:0] z_raw;
  logic                          flip;
  logic signed [PROD_WIDTH-1:0]  px_round, py_round;

  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s1_valid_d = s1_ready ? in_valid_i : s1_valid_q;
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;

  // Fold phases beyond a quarter turn by half a turn and negate the start vector
  always_comb begin
    z_raw    = $signed(s1_phase_q);
    flip     = (z_raw > QUARTER_TURN) || (z_raw < -QUARTER_TURN);
    px_round = s1_px_q + HALF_LSB;
    py_round = s1_py_q + HALF_LSB;
    s2_data_d.z = flip ? {~z_raw[PHASE_WIDTH-1], z_raw[PHASE_WIDTH-2:0]} : z_raw;
    s2_data_d.x = flip ? -CORDIC_GAIN : CORDIC_GAIN;
    s2_data_d.y = '0;
    s2_data_d.a = px_round[PROD_WIDTH-1:SCALE_FRAC];
    s2_data_d.b = py_round[PROD_WIDTH-1:SCALE_FRAC];
  end

  // Hold or advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Load payloads when the stage takes a transaction
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_phase_q <= phase_sum[PHASE_WIDTH-1:0];
      s1_px_q    <= prod_x;
      s1_py_q    <= prod_y;
    end
    if (s2_ready && s1_valid_q) begin
      s2_data_q <= s2_data_d;
    end
  end

  assign in_ready_o  = s1_ready;
  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

endmodule

// ----- rtl/psrt_cell.sv -----
// ----------------------------------------------------------------------------
// psrt_cell
// One rotation cell: a single CORDIC micro-rotation on a registered vector,
// passing the scaled point along with it.
// ----------------------------------------------------------------------------
module psrt_cell
  import psrt_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  rot_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rot_t out_data_o
);

  localparam logic signed [PHASE_WIDTH-1:0] ANGLE_STEP = atan_phase(STAGE);

  logic                        valid_q, valid_d, ready;
  rot_t                        data_q, data_d;
  logic signed [VEC_WIDTH-1:0] dx, dy;

  // Rotate toward zero residual phase
  always_comb begin
    dx     = in_data_i.y >>> STAGE;
    dy     = in_data_i.x >>> STAGE;
    data_d = in_data_i;
    if (!in_data_i.z[PHASE_WIDTH-1]) begin
      data_d.x = in_data_i.x - dx;
      data_d.y = in_data_i.y + dy;
      data_d.z = in_data_i.z - ANGLE_STEP;
    end else begin
      data_d.x = in_data_i.x + dx;
      data_d.y = in_data_i.y - dy;
      data_d.z = in_data_i.z + ANGLE_STEP;
    end
  end

  assign ready   = !valid_q || out_ready_i;
  assign valid_d = ready ? in_valid_i : valid_q;

  // Hold or advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load the rotated vector
  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign in_ready_o  = ready;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Residual phase never leaves the folded quarter-turn range
  a_phase_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (data_q.z <= QUARTER_TURN) && (data_q.z >= -QUARTER_TURN))
    else $error("psrt_cell: residual phase out of range");

endmodule

// ----- rtl/psrt_back.sv -----
// ----------------------------------------------------------------------------
// psrt_back
// Stages after the rotation chain: cosine/sine rounding, the four products,
// rounded sums, translation and saturation into the output register.
// ----------------------------------------------------------------------------
module psrt_back
  import psrt_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [COORD_WIDTH-1:0] shift_x_i,
  input  logic signed [COORD_WIDTH-1:0] shift_y_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rot_t                          in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output result_t                       out_data_o
);

  localparam int RND_WIDTH = VEC_WIDTH + 1;
  localparam int TRIG_RAW  = RND_WIDTH - TRIG_DROP;
  localparam logic signed [RND_WIDTH-1:0]  TRIG_HALF = RND_WIDTH'(1 << (TRIG_DROP - 1));
  localparam logic signed [TRIG_RAW-1:0]   TRIG_MAX  = TRIG_RAW'(1 << TRIG_FRAC);
  localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE  = TRIG_WIDTH'(1 << TRIG_FRAC);
  localparam logic signed [SUM_WIDTH-1:0]  MIX_HALF  = SUM_WIDTH'(1 << (TRIG_FRAC - 1));
  localparam logic signed [TRANS_WIDTH-1:0] OUT_MAX =
    TRANS_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [TRANS_WIDTH-1:0] OUT_MIN = -OUT_MAX - TRANS_WIDTH'(1);
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = OUT_MAX[COORD_WIDTH-1:0];
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = OUT_MIN[COORD_WIDTH-1:0];

  // Round a Q2.30 vector component to Q1.14 and clamp to plus/minus one
  function automatic logic signed [TRIG_WIDTH-1:0] to_trig(input logic signed [VEC_WIDTH-1:0] v);
    logic signed [RND_WIDTH-1:0] r;
    logic signed [TRIG_RAW-1:0]  t;
    logic signed [TRIG_WIDTH-1:0] res;
    r = RND_WIDTH'(v) + TRIG_HALF;
    t = r[RND_WIDTH-1:TRIG_DROP];
    if (t > TRIG_MAX) begin
      res = TRIG_MAX[TRIG_WIDTH-1:0];
    end else if (t < -TRIG_MAX) begin
      res = -TRIG_MAX[TRIG_WIDTH-1:0];
    end else begin
      res = t[TRIG_WIDTH-1:0];
    end
    return res;
  endfunction

  // Saturate a translated coordinate
  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [TRANS_WIDTH-1:0] v);
    logic signed [COORD_WIDTH-1:0] res;
    if (v > OUT_MAX) begin
      res = COORD_MAX;
    end else if (v < OUT_MIN) begin
      res = COORD_MIN;
    end else begin
      res = v[COORD_WIDTH-1:0];
    end
    return res;
  endfunction

  // Stage registers
  logic                           b1_valid_q, b2_valid_q, b3_valid_q, b4_valid_q;
  logic                           b1_ready, b2_ready, b3_ready, b4_ready;
  logic signed [TRIG_WIDTH-1:0]   b1_cos_q, b1_sin_q;
  logic signed [SCALED_WIDTH-1:0] b1_a_q, b1_b_q;
  logic signed [MIX_WIDTH-1:0]    b2_ac_q, b2_bs_q, b2_as_q, b2_bc_q;
  logic signed [ROT_WIDTH-1:0]    b3_rx_q, b3_ry_q;
  result_t                        b4_res_q, b4_res_d;

  logic signed [SUM_WIDTH-1:0]    sum_x, sum_y;
  logic signed [TRANS_WIDTH-1:0]  tx, ty;

  // Ready ripples back from the output register
  assign b4_ready = !b4_valid_q || out_ready_i;
  assign b3_ready = !b3_valid_q || b4_ready;
  assign b2_ready = !b2_valid_q || b3_ready;
  assign b1_ready = !b1_valid_q || b2_ready;

  // Rounded rotation sums
  assign sum_x = SUM_WIDTH'(b2_ac_q) - SUM_WIDTH'(b2_bs_q) + MIX_HALF;
  assign sum_y = SUM_WIDTH'(b2_as_q) + SUM_WIDTH'(b2_bc_q) + MIX_HALF;

  // Translate and saturate
  always_comb begin
    tx = TRANS_WIDTH'(b3_rx_q) + TRANS_WIDTH'(shift_x_i);
    ty = TRANS_WIDTH'(b3_ry_q) + TRANS_WIDTH'(shift_y_i);
    b4_res_d.out_x   = sat(tx);
    b4_res_d.out_y   = sat(ty);
    b4_res_d.clipped = (tx > OUT_MAX) || (tx < OUT_MIN) || (ty > OUT_MAX) || (ty < OUT_MIN);
  end

  // Hold or advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      b3_valid_q <= 1'b0;
      b4_valid_q <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_valid_q <= in_valid_i;
      end
      if (b2_ready) begin
        b2_valid_q <= b1_valid_q;
      end
      if (b3_ready) begin
        b3_valid_q <= b2_valid_q;
      end
      if (b4_ready) begin
        b4_valid_q <= b3_valid_q;
      end
    end
  end

  // Load payloads
  always_ff @(posedge clk_i) begin
    if (b1_ready && in_valid_i) begin
      b1_cos_q <= to_trig(in_data_i.x);
      b1_sin_q <= to_trig(in_data_i.y);
      b1_a_q   <= in_data_i.a;
      b1_b_q   <= in_data_i.b;
    end
    if (b2_ready && b1_valid_q) begin
      b2_ac_q <= MIX_WIDTH'(b1_a_q * b1_cos_q);
      b2_bs_q <= MIX_WIDTH'(b1_b_q * b1_sin_q);
      b2_as_q <= MIX_WIDTH'(b1_a_q * b1_sin_q);
      b2_bc_q <= MIX_WIDTH'(b1_b_q * b1_cos_q);
    end
    if (b3_ready && b2_valid_q) begin
      b3_rx_q <= sum_x[SUM_WIDTH-1:TRIG_FRAC];
      b3_ry_q <= sum_y[SUM_WIDTH-1:TRIG_FRAC];
    end
    if (b4_ready && b3_valid_q) begin
      b4_res_q <= b4_res_d;
    end
  end

  assign in_ready_o  = b1_ready;
  assign out_valid_o = b4_valid_q;
  assign out_data_o  = b4_res_q;

  // Cosine and sine stay within plus/minus one
  a_trig_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b1_valid_q |-> (b1_cos_q <= TRIG_ONE) && (b1_cos_q >= -TRIG_ONE)
                && (b1_sin_q <= TRIG_ONE) && (b1_sin_q >= -TRIG_ONE))
    else $error("psrt_back: trig value out of range");

  // A clipped transaction carries at least one coordinate at a rail
  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b4_valid_q && b4_res_q.clipped) |->
      (b4_res_q.out_x == COORD_MAX) || (b4_res_q.out_x == COORD_MIN) ||
      (b4_res_q.out_y == COORD_MAX) || (b4_res_q.out_y == COORD_MIN))
    else $error("psrt_back: clipped flag without saturated coordinate");

endmodule

// ----- test/point_scale_rotate_translate_checker.sv -----
// ----------------------------------------------------------------------------
// point_scale_rotate_translate_checker
// Watches the configuration port and both streaming channels of the point
// transform block. It keeps its own copy of the registers and computes the
// expected scaled, rotated and translated point for every accepted input
// transaction. Each accepted output transaction is compared against the
// oldest expectation. A mismatch count and the number of outstanding
// expectations are handed to the testbench top.
// ----------------------------------------------------------------------------
module point_scale_rotate_translate_checker
  import psrt_pkg::*;
#(
  parameter int ROTATION_STAGES = DEF_ROTATION_STAGES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]     cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  point_t                   in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  result_t                  out_data_i,
  output int                       fault_count_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint UNITY_SCALE  = 256;
  localparam longint TURN_STEPS   = 5760;
  localparam longint TRIG_ONE     = 16384;
  localparam longint COORD_MAX    = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN    = -COORD_MAX - 1;
  localparam int     REPORT_LIMIT = 10;

  // Arctangent of 2^-i as a fraction of a turn, 2^32 per turn
  longint atan_turn [0:ATAN_ENTRIES-1] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  // Shadow copy of the configuration registers
  logic signed [COORD_WIDTH-1:0] scale_x_q, scale_y_q, shift_x_q, shift_y_q;
  logic        [ANGLE_WIDTH-1:0] angle_q;

  result_t transformed_q [$];
  int      faults;

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Cosine and sine in Q1.14 by gain-corrected vector rotation
  function automatic void rotation_trig(input logic [ANGLE_WIDTH-1:0] angle,
                                        output longint cos_q14,
                                        output longint sin_q14);
    longint turn, phase, vx, vy, dx, dy;
    bit     flip;
    int     i;
    turn = longint'(angle);
    if (turn >= TURN_STEPS) begin
      turn -= TURN_STEPS;
    end
    phase = ((turn <<< 32) + TURN_STEPS / 2) / TURN_STEPS;
    if (phase >= (longint'(1) <<< 31)) begin
      phase -= longint'(1) <<< 32;
    end
    // Fold the back half-plane onto the front one
    flip = 1'b0;
    if (phase > (longint'(1) <<< 30)) begin
      phase -= longint'(1) <<< 31;
      flip = 1'b1;
    end else if (phase < -(longint'(1) <<< 30)) begin
      phase += longint'(1) <<< 31;
      flip = 1'b1;
    end
    vx = flip ? -longint'(CORDIC_GAIN) : longint'(CORDIC_GAIN);
    vy = 0;
    for (i = 0; i < ROTATION_STAGES && i < ATAN_ENTRIES; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (phase >= 0) begin
        vx -= dx;
        vy += dy;
        phase -= atan_turn[i];
      end else begin
        vx += dx;
        vy -= dy;
        phase += atan_turn[i];
      end
    end
    cos_q14 = clamp_to((vx + 32768) >>> 16, -TRIG_ONE, TRIG_ONE);
    sin_q14 = clamp_to((vy + 32768) >>> 16, -TRIG_ONE, TRIG_ONE);
  endfunction

  // Scale, rotate, translate and saturate one point
  function automatic result_t transform_point(input point_t pt);
    longint  px, py, c, s, a, b, rx, ry, ox, oy;
    result_t res;
    px = longint'($signed(pt.point_x));
    py = longint'($signed(pt.point_y));
    rotation_trig(angle_q, c, s);
    a  = (px * longint'(scale_x_q) + 128) >>> 8;
    b  = (py * longint'(scale_y_q) + 128) >>> 8;
    rx = ((a * c - b * s + 8192) >>> 14) + longint'(shift_x_q);
    ry = ((a * s + b * c + 8192) >>> 14) + longint'(shift_y_q);
    ox = clamp_to(rx, COORD_MIN, COORD_MAX);
    oy = clamp_to(ry, COORD_MIN, COORD_MAX);
    res.out_x   = ox[COORD_WIDTH-1:0];
    res.out_y   = oy[COORD_WIDTH-1:0];
    res.clipped = (ox != rx) || (oy != ry);
    return res;
  endfunction

  // Track registers, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      scale_x_q = COORD_WIDTH'(UNITY_SCALE);
      scale_y_q = COORD_WIDTH'(UNITY_SCALE);
      angle_q   = '0;
      shift_x_q = '0;
      shift_y_q = '0;
      transformed_q.delete();
      faults = 0;
      fault_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SCALE_X:   scale_x_q = cfg_data_i;
          REG_SCALE_Y:   scale_y_q = cfg_data_i;
          REG_ROT_ANGLE: angle_q   = cfg_data_i[ANGLE_WIDTH-1:0];
          REG_SHIFT_X:   shift_x_q = cfg_data_i;
          REG_SHIFT_Y:   shift_y_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        transformed_q.push_back(transform_point(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (transformed_q.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT) begin
            $display("%t: result with nothing outstanding: x=%0d y=%0d clipped=%0b",
                     $realtime, $signed(out_data_i.out_x), $signed(out_data_i.out_y),
                     out_data_i.clipped);
          end
        end else begin
          want = transformed_q.pop_front();
          if (out_data_i.out_x !== want.out_x || out_data_i.out_y !== want.out_y ||
              out_data_i.clipped !== want.clipped) begin
            faults++;
            if (faults <= REPORT_LIMIT) begin
              $display("%t: mismatch: expected x=%0d y=%0d clipped=%0b, got x=%0d y=%0d clipped=%0b",
                       $realtime, $signed(want.out_x), $signed(want.out_y), want.clipped,
                       $signed(out_data_i.out_x), $signed(out_data_i.out_y),
                       out_data_i.clipped);
            end
          end
        end
      end
      fault_count_o <= faults;
      pending_o     <= transformed_q.size();
    end
  end

endmodule

// ----- test/point_scale_rotate_translate_test.sv -----
// ----------------------------------------------------------------------------
// point_scale_rotate_translate_test
// Drives the point transform block with directed corner points under reset
// and extreme register settings, then with random points under a series of
// random settings; both channels idle at random except in the last third of
// the segments. A checker module alongside the block predicts and compares
// every transaction; this top gives the verdict.
// ----------------------------------------------------------------------------
module point_scale_rotate_translate_test;
  import psrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY  = DEF_ROTATION_STAGES + 6;
  localparam int SEGMENTS      = 12;
  localparam int SEGMENT_ITEMS = 85;
  localparam int CORNERS       = 8;
  localparam int UPPER_WIDTH   = CFG_WIDTH - ANGLE_WIDTH;
  localparam logic [CFG_WIDTH-1:0] COORD_TOP    = 16'h7FFF;
  localparam logic [CFG_WIDTH-1:0] COORD_BOTTOM = 16'h8000;
  localparam logic [CFG_WIDTH-1:0] UNITY        = 16'd256;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx    = '0;
  logic [CFG_WIDTH-1:0]     cfg_data   = '0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  point_t                   in_data    = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  result_t                  out_data;
  int                       fault_count;
  int                       pending;
  int                       send_idle_pct = 23;
  int                       recv_stall_pct = 73;

  point_scale_rotate_translate dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  point_scale_rotate_translate_checker transform_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .fault_count_o (fault_count),
    .pending_o     (pending)
  );

  // Free-running clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver stalls at random
  initial begin
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Stop a hung run
  initial begin
    #400us;
    $display("Verification failed");
    $finish;
  end

  // Offer one point, idling first at random, and hold it until accepted
  task automatic send_point(input point_t pt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Drop valid, wait until every expected result has arrived, then settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Load all registers, then poke an unused index that must be ignored
  task automatic apply_config(input logic [CFG_WIDTH-1:0] sx, input logic [CFG_WIDTH-1:0] sy,
                              input logic [CFG_WIDTH-1:0] ang, input logic [CFG_WIDTH-1:0] tx,
                              input logic [CFG_WIDTH-1:0] ty);
    logic [CFG_IDX_WIDTH-1:0] spare_idx;
    spare_idx = CFG_IDX_WIDTH'($urandom_range((1 << CFG_IDX_WIDTH) - 1, REG_SHIFT_Y + 1));
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_ROT_ANGLE, ang);
    write_reg(REG_SHIFT_X, tx);
    write_reg(REG_SHIFT_Y, ty);
    write_reg(spare_idx, CFG_WIDTH'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic point_t corner_point(input int idx);
    point_t pt;
    case (idx)
      0:       pt = '{point_x: 16'sd0,      point_y: 16'sd0};
      1:       pt = '{point_x: COORD_TOP,    point_y: COORD_TOP};
      2:       pt = '{point_x: COORD_BOTTOM, point_y: COORD_BOTTOM};
      3:       pt = '{point_x: COORD_TOP,    point_y: COORD_BOTTOM};
      4:       pt = '{point_x: COORD_BOTTOM, point_y: COORD_TOP};
      5:       pt = '{point_x: 16'sd1,      point_y: -16'sd1};
      6:       pt = '{point_x: 16'sd256,    point_y: 16'sd256};
      default: pt = '{point_x: -16'sd256,   point_y: 16'sd128};
    endcase
    return pt;
  endfunction

  // Coordinate mix: full range, near the origin, or an edge value
  function automatic logic [CFG_WIDTH-1:0] random_coord(input int spread);
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) begin
      return CFG_WIDTH'($urandom);
    end else if (pick < 8) begin
      return CFG_WIDTH'($urandom_range(2 * spread) - spread);
    end
    case ($urandom_range(4))
      0:       return COORD_TOP;
      1:       return COORD_BOTTOM;
      2:       return '0;
      3:       return CFG_WIDTH'(1);
      default: return '1;
    endcase
  endfunction

  // Angle mix: ends of the turn, quarter turns, out of range, random
  function automatic logic [CFG_WIDTH-1:0] random_angle();
    logic [ANGLE_WIDTH-1:0] ang;
    logic [UPPER_WIDTH-1:0] upper;
    upper = UPPER_WIDTH'($urandom);
    case ($urandom_range(7))
      0:       ang = '0;
      1:       ang = FULL_TURN - ANGLE_WIDTH'(1);
      2:       ang = ANGLE_WIDTH'($urandom_range((1 << ANGLE_WIDTH) - 1, FULL_TURN));
      3:       ang = ANGLE_WIDTH'(($urandom_range(3) * FULL_TURN) / 4);
      default: ang = ANGLE_WIDTH'($urandom_range(FULL_TURN - 1));
    endcase
    return {upper, ang};
  endfunction

  // Main sequence
  initial begin
    point_t pt;
    int     seg;
    int     n;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values on the corner points
    for (n = 0; n < CORNERS; n++) begin
      send_point(corner_point(n));
    end

    // Extreme scales and shifts, quarter and three-quarter turns
    wait_idle();
    apply_config(COORD_BOTTOM, COORD_TOP, CFG_WIDTH'(FULL_TURN / 4), COORD_TOP, COORD_BOTTOM);
    for (n = 0; n < 4; n++) send_point(corner_point(n + 1));
    wait_idle();
    apply_config(COORD_TOP, COORD_BOTTOM, CFG_WIDTH'(3 * (FULL_TURN / 4)), COORD_BOTTOM,
                 COORD_TOP);
    for (n = 0; n < 4; n++) send_point(corner_point(n + 4));

    // Angle past a full turn with upper data bits set, then a half turn
    wait_idle();
    apply_config(UNITY, -UNITY, '1, '0, '0);
    for (n = 0; n < 4; n++) send_point(corner_point(n));
    wait_idle();
    apply_config(CFG_WIDTH'(1), CFG_WIDTH'(1), CFG_WIDTH'(FULL_TURN / 2), CFG_WIDTH'(1), '1);
    for (n = 0; n < 4; n++) send_point(corner_point(n + 4));

    // Random segments across three idling phases
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == SEGMENTS / 3) begin
        wait_idle();
        send_idle_pct  = 73;
        recv_stall_pct = 23;
      end else if (seg == 2 * SEGMENTS / 3) begin
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      wait_idle();
      apply_config(random_coord(1024), random_coord(1024), random_angle(),
                   random_coord(4096), random_coord(4096));
      for (n = 0; n < SEGMENT_ITEMS; n++) begin
        // Hold off mid-segment until the pipeline has drained
        if (n == SEGMENT_ITEMS / 2) begin
          wait_idle();
        end
        pt.point_x = random_coord(2048);
        pt.point_y = random_coord(2048);
        send_point(pt);
      end
    end

    wait_idle();
    repeat (PIPE_LATENCY) @(posedge clk);
    if (fault_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/psrt_pkg.sv
rtl/psrt_front.sv
rtl/psrt_cell.sv
rtl/psrt_back.sv
rtl/point_scale_rotate_translate.sv
test/point_scale_rotate_translate_checker.sv
test/point_scale_rotate_translate_test.sv
